// File: hw/rtl/afm_pkg.sv
// Shared types, constants and the sine level table of the ASK/FSK byte modulator.
package afm_pkg;

  localparam int unsigned TABLE_LENGTH = 50;
  localparam int unsigned IDX_W        = 6;
  localparam int unsigned BIT_W        = 4;
  localparam int unsigned LEVEL_W      = 8;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [BIT_W-1:0]   bitcnt_t;

  // Ticks per bit and per gap, DAC levels, bit counter bounds and FSK index steps
  localparam idx_t    PERIOD_LAST   = IDX_W'(TABLE_LENGTH - 1);
  localparam level_t  MID_LEVEL     = 8'd115;
  localparam level_t  START_MARK    = 8'h80;
  localparam bitcnt_t LAST_DATA_BIT = 4'd7;
  localparam bitcnt_t BIT_END       = 4'd9;
  localparam idx_t    STEP_ONE      = 6'd2;
  localparam idx_t    STEP_ZERO     = 6'd1;

  // Command queue between front and back
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_PTR_W = 2;
  localparam int unsigned CMDQ_CNT_W = 3;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LOAD = 2'd1,
    PH_SEND = 2'd2,
    PH_GAP  = 2'd3
  } phase_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_PUSH = 1'b1
  } op_t;

  typedef struct packed {
    op_t    op;
    level_t data;
  } cmd_t;

  // DAC code per table entry: MID_LEVEL plus 114*sin(2*pi*n/50), truncated
  localparam level_t SINE_LEVEL [0:TABLE_LENGTH-1] = '{
    8'd115, 8'd129, 8'd143, 8'd156, 8'd169, 8'd182, 8'd193, 8'd202, 8'd211, 8'd218,
    8'd223, 8'd226, 8'd228, 8'd228, 8'd226, 8'd223, 8'd218, 8'd211, 8'd202, 8'd193,
    8'd182, 8'd169, 8'd156, 8'd143, 8'd129, 8'd115, 8'd101, 8'd87,  8'd74,  8'd61,
    8'd48,  8'd37,  8'd28,  8'd19,  8'd12,  8'd7,   8'd4,   8'd2,   8'd2,   8'd4,
    8'd7,   8'd12,  8'd19,  8'd28,  8'd37,  8'd48,  8'd61,  8'd74,  8'd87,  8'd101
  };

  // Out-of-table index reads as silence
  function automatic level_t sine_level(input idx_t idx);
    level_t lvl;
    lvl = MID_LEVEL;
    if (idx < IDX_W'(TABLE_LENGTH)) begin
      lvl = SINE_LEVEL[idx];
    end
    return lvl;
  endfunction

endpackage

// File: hw/rtl/afm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module afm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/afm_front.sv
// Front end: accept input beats, classify them and queue them for the sender.
module afm_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_op,
  input  logic [7:0]    in_data,
  output logic          cmd_valid,
  output afm_pkg::cmd_t cmd,
  input  logic          cmd_ready
);
  import afm_pkg::*;

  cmd_t                  q_mem [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] rd_ptr;
  logic [CMDQ_PTR_W-1:0] wr_ptr;
  logic [CMDQ_CNT_W-1:0] q_count;
  logic                  q_push;
  logic                  q_pop;
  cmd_t                  in_cmd;

  assign in_ready  = (q_count != CMDQ_CNT_W'(CMDQ_DEPTH));
  assign cmd_valid = (q_count != '0);
  assign cmd       = q_mem[rd_ptr];
  assign q_push    = in_valid && in_ready;
  assign q_pop     = cmd_valid && cmd_ready;

  // Classify: tick or push
  always_comb begin
    in_cmd.op   = in_op ? OP_PUSH : OP_TICK;
    in_cmd.data = in_data;
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr  <= '0;
      wr_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (q_push) begin
        wr_ptr <= wr_ptr + CMDQ_PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + CMDQ_PTR_W'(1);
      end
      if (q_push && !q_pop) begin
        q_count <= q_count + CMDQ_CNT_W'(1);
      end else if (q_pop && !q_push) begin
        q_count <= q_count - CMDQ_CNT_W'(1);
      end
    end
  end

endmodule

// File: hw/rtl/afm_back.sv
// Back end: byte FIFO, bit sender state machine and the result register.
module afm_back #(
  parameter int FIFO_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data,
  input  logic          cmd_valid,
  input  afm_pkg::cmd_t cmd,
  output logic          cmd_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_dac_level,
  output logic          out_sending,
  output logic          out_push_dropped
);
  import afm_pkg::*;

  localparam int ADDR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);

  logic              ask_mode;
  logic [ADDR_W-1:0] head, head_next;
  logic [ADDR_W-1:0] tail, tail_next;
  logic [CNT_W-1:0]  fifo_count, fifo_count_next;
  phase_t            phase, phase_next;
  level_t            shift_byte, shift_byte_next;
  logic              current_bit, current_bit_next;
  bitcnt_t           bit_counter, bit_counter_next;
  idx_t              period_counter, period_counter_next;
  idx_t              phase_index, phase_index_next;
  level_t            held_level, held_level_next;
  logic              dropped;
  logic              exec;
  logic              fifo_we;
  level_t            fifo_rdata;
  logic [2:0]        bit_sel;
  idx_t              fsk_index;

  assign cmd_ready = !out_valid || out_ready;
  assign exec      = cmd_valid && cmd_ready;

  // Read port sits on the head entry all the time; a load always follows an
  // idle tick that comes after the push that filled it.
  afm_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (tail),
    .wdata (cmd.data),
    .raddr (head),
    .rdata (fifo_rdata)
  );

  always_comb begin
    head_next           = head;
    tail_next           = tail;
    fifo_count_next     = fifo_count;
    phase_next          = phase;
    shift_byte_next     = shift_byte;
    current_bit_next    = current_bit;
    bit_counter_next    = bit_counter;
    period_counter_next = period_counter;
    phase_index_next    = phase_index;
    held_level_next     = held_level;
    dropped             = 1'b0;
    fifo_we             = 1'b0;
    bit_sel             = 3'(LAST_DATA_BIT - bit_counter);
    fsk_index           = phase_index + (current_bit ? STEP_ONE : STEP_ZERO);

    if (exec && cmd.op == OP_PUSH) begin
      if (fifo_count < CNT_W'(FIFO_DEPTH)) begin
        fifo_we         = 1'b1;
        fifo_count_next = fifo_count + CNT_W'(1);
        tail_next       = (tail == ADDR_W'(FIFO_DEPTH - 1)) ? '0 : tail + ADDR_W'(1);
      end else begin
        dropped = 1'b1;
      end
    end else if (exec) begin
      case (phase)
        PH_IDLE: begin
          if (fifo_count != '0) begin
            phase_next = PH_LOAD;
          end else begin
            held_level_next = MID_LEVEL;
          end
        end
        PH_LOAD: begin
          shift_byte_next     = fifo_rdata | START_MARK;
          head_next           = (head == ADDR_W'(FIFO_DEPTH - 1)) ? '0 : head + ADDR_W'(1);
          fifo_count_next     = fifo_count - CNT_W'(1);
          period_counter_next = '0;
          phase_index_next    = '0;
          current_bit_next    = 1'b1;
          bit_counter_next    = 4'd1;
          phase_next          = PH_SEND;
        end
        PH_SEND: begin
          if (ask_mode) begin
            held_level_next = current_bit ? sine_level(period_counter) : MID_LEVEL;
          end else begin
            held_level_next  = sine_level(phase_index);
            phase_index_next = (fsk_index >= PERIOD_LAST) ? '0 : fsk_index;
          end
          period_counter_next = period_counter + IDX_W'(1);
          if (period_counter_next >= PERIOD_LAST) begin
            // Next bit MSB first; past bit 0 the stray bit reads as zero
            current_bit_next    = (bit_counter <= LAST_DATA_BIT) ? shift_byte[bit_sel] : 1'b0;
            phase_index_next    = '0;
            period_counter_next = '0;
            bit_counter_next    = bit_counter + BIT_W'(1);
            if (bit_counter_next >= BIT_END) begin
              phase_next       = PH_GAP;
              bit_counter_next = '0;
            end
          end
        end
        PH_GAP: begin
          held_level_next  = MID_LEVEL;
          phase_index_next = phase_index + IDX_W'(1);
          if (phase_index_next >= PERIOD_LAST) begin
            phase_next = PH_IDLE;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ask_mode       <= 1'b1;
      head           <= '0;
      tail           <= '0;
      fifo_count     <= '0;
      phase          <= PH_IDLE;
      shift_byte     <= '0;
      current_bit    <= 1'b0;
      bit_counter    <= '0;
      period_counter <= '0;
      phase_index    <= '0;
      held_level     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        ask_mode <= cfg_wr_data;
      end
      head           <= head_next;
      tail           <= tail_next;
      fifo_count     <= fifo_count_next;
      phase          <= phase_next;
      shift_byte     <= shift_byte_next;
      current_bit    <= current_bit_next;
      bit_counter    <= bit_counter_next;
      period_counter <= period_counter_next;
      phase_index    <= phase_index_next;
      held_level     <= held_level_next;
      if (exec) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_dac_level    <= held_level_next;
      out_sending      <= (phase_next != PH_IDLE);
      out_push_dropped <= dropped;
    end
  end

endmodule

// File: hw/rtl/ask_fsk_byte_modulator.sv
// Top level of the ASK/FSK byte modulator: command front end, sender back end.
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tuser: operation, tdata: data_byte
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata: dac_level, sending, push_dropped
//  cfg       in   cfg_wr_en (no wait)             cfg_wr_data: modulation_mode (1 = ASK)
//
//  Sustained rate is one beat per cycle in and one result per cycle out unless m_axis
//  stalls; the sender state advances once per executed beat, so the back end sets it.
//  An accepted beat goes through the command queue, then into the m_axis result register.
//  rst is synchronous: it clears queue, FIFO pointers, sender state and the mode
//  register (back to ASK); the FIFO RAM itself is not cleared and needs no pass.
//  When m_axis stalls the result register holds, the 4-entry command queue absorbs
//  up to four more beats, and only then is s_axis_tready dropped.
module ask_fsk_byte_modulator #(
  parameter int FIFO_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,     // modulation_mode
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,    // [0] operation (0 tick, 1 push)
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata     // [7:0] dac_level, [8] sending, [9] push_dropped
);
  import afm_pkg::*;

  cmd_t   cmd;
  logic   cmd_valid;
  logic   cmd_ready;
  level_t dac_level;
  logic   sending;
  logic   push_dropped;

  // Accept and classify beats into the command queue
  afm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser[0]),
    .in_data   (s_axis_tdata),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  // Execute pushes and sample ticks in order, hold the result for m_axis
  afm_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_ready        (cmd_ready),
    .out_valid        (m_axis_tvalid),
    .out_ready        (m_axis_tready),
    .out_dac_level    (dac_level),
    .out_sending      (sending),
    .out_push_dropped (push_dropped)
  );

  // Pack result fields, zero-fill to 16 bits
  assign m_axis_tdata = {6'd0, push_dropped, sending, dac_level};

endmodule

// File: hw/rtl/afm_checker.sv
// Port-level checks for the ASK/FSK byte modulator, bound to the top level.
module afm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // Reset empties the result register
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds its data
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Input back-pressure only follows a stalled result
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a stalled result");

  // Outside a byte the DAC is silent, or still at its reset code
  a_silent_level: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'd115 ||
                                          m_axis_tdata[7:0] == 8'd0)
    else $error("idle DAC level not mid-level");

  // Sine peak bounds the DAC code
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[7:0] <= 8'd228)
    else $error("DAC level above sine peak");

endmodule

bind ask_fsk_byte_modulator afm_checker u_afm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
